>>> design/primitive_to_conservative_defines.svh
// Assertion macros shared by the conversion block.
`ifndef PRIMITIVE_TO_CONSERVATIVE_DEFINES_SVH
`define PRIMITIVE_TO_CONSERVATIVE_DEFINES_SVH

// Checks in the same cycle that pre implies post.
`define P2C_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Checks that pre in one cycle implies post in the next cycle.
`define P2C_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> design/p2c_pkg.sv
// Shared types and constants of the primitive to conservative converter.
package p2c_pkg;

  localparam int GRID_X = 512;
  localparam int GRID_Y = 256;

  // Rows of the two source circle centers.
  localparam int ROW_C1 = GRID_Y / 4;
  localparam int ROW_C2 = 3 * GRID_Y / 4;

  localparam int COL_W  = 9;
  localparam int ROW_W  = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 48;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE    = 3'd0,
    CFG_COLUMN    = 3'd1,
    CFG_RADIUS_SQ = 3'd2,
    CFG_DENSITY   = 3'd3,
    CFG_ENERGY    = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic               enable;
    logic [COL_W-1:0]   column;
    logic [15:0]        radius_sq;
    logic [30:0]        density;
    logic signed [47:0] energy;
  } p2c_cfg_t;

endpackage

>>> design/primitive_to_conservative.sv
// Top level: pipelined primitive to conservative conversion of one grid cell per word.
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_stall  | column, row, density, velocities, energy,
//           |           |                      | three mass fractions
//   out_    | output    | out_valid / out_stall| density, momenta, total energy, species
//           |           |                      | densities, in_source flag
//   cfg_    | input     | cfg_valid / cfg_ready| register index, write data (always ready)
//
// One word enters per cycle while in_stall is low; the depth of the pipeline is set by the
// squaring of the velocities, the total energy add and the split 31 by 49 bit energy product.
// Reset clears the valid bits of all six stages and loads the register defaults.
// Each stage loads when it is empty or its successor moves, so bubbles close up under an
// output stall and in_stall rises only when every stage holds a word.
`include "primitive_to_conservative_defines.svh"

module primitive_to_conservative (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input channel.
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [p2c_pkg::COL_W-1:0]         in_column,
  input  logic [p2c_pkg::ROW_W-1:0]         in_row,
  input  logic [30:0]                       in_density,
  input  logic signed [31:0]                in_velocity_x,
  input  logic signed [31:0]                in_velocity_y,
  input  logic signed [47:0]                in_internal_energy,
  input  logic [16:0]                       in_frac_hydrogen,
  input  logic [16:0]                       in_frac_oxygen,
  input  logic [16:0]                       in_frac_water,
  // Result channel.
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [30:0]                       out_cons_density,
  output logic signed [31:0]                out_momentum_x,
  output logic signed [31:0]                out_momentum_y,
  output logic signed [47:0]                out_total_energy,
  output logic [30:0]                       out_dens_hydrogen,
  output logic [30:0]                       out_dens_oxygen,
  output logic [30:0]                       out_dens_water,
  output logic                              out_in_source,
  // Configuration write channel.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [p2c_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [p2c_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // Rounds a Q.32 product of up to 63 bits to Q.16, ties away from zero on the
  // magnitude, and saturates to signed 32 bits.
  function automatic logic [31:0] rnd_sat_s32(input logic [62:0] prod, input logic neg);
    logic [63:0] sum;
    logic [47:0] q;
    logic [47:0] lim;
    logic [47:0] qc;
    sum = {1'b0, prod} + 64'h8000;
    q   = sum[63:16];
    lim = neg ? 48'h0000_8000_0000 : 48'h0000_7FFF_FFFF;
    qc  = (q > lim) ? lim : q;
    return neg ? (32'h0 - qc[31:0]) : qc[31:0];
  endfunction

  // Same rounding for the 80 bit energy product, saturating to signed 48 bits.
  function automatic logic [47:0] rnd_sat_s48(input logic [79:0] prod, input logic neg);
    logic [80:0] sum;
    logic [64:0] q;
    logic [64:0] lim;
    logic [64:0] qc;
    sum = {1'b0, prod} + 81'h8000;
    q   = sum[80:16];
    lim = neg ? 65'h0_0000_8000_0000_0000 : 65'h0_0000_7FFF_FFFF_FFFF;
    qc  = (q > lim) ? lim : q;
    return neg ? (48'h0 - qc[47:0]) : qc[47:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes are always taken; unknown indexes are dropped.
  // ---------------------------------------------------------------------------
  p2c_pkg::p2c_cfg_t cfg_r, cfg_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (p2c_pkg::cfg_idx_t'(cfg_index))
        p2c_pkg::CFG_ENABLE:    cfg_nxt.enable    = cfg_data[0];
        p2c_pkg::CFG_COLUMN:    cfg_nxt.column    = cfg_data[p2c_pkg::COL_W-1:0];
        p2c_pkg::CFG_RADIUS_SQ: cfg_nxt.radius_sq = cfg_data[15:0];
        p2c_pkg::CFG_DENSITY:   cfg_nxt.density   = cfg_data[30:0];
        p2c_pkg::CFG_ENERGY:    cfg_nxt.energy    = cfg_data[47:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable    <= 1'b1;
      cfg_r.column    <= p2c_pkg::COL_W'(20);
      cfg_r.radius_sq <= 16'd25;
      cfg_r.density   <= 31'd65536;
      cfg_r.energy    <= 48'sd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage flow control. A stage moves when it is empty or the next one moves.
  // ---------------------------------------------------------------------------
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r, out_valid_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

  assign rdy6     = !out_valid_r || !out_stall;
  assign rdy5     = !s5_v_r || rdy6;
  assign rdy4     = !s4_v_r || rdy5;
  assign rdy3     = !s3_v_r || rdy4;
  assign rdy2     = !s2_v_r || rdy3;
  assign rdy1     = !s1_v_r || rdy2;
  assign in_stall = !rdy1;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      s5_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1) s1_v_r      <= in_valid;
      if (rdy2) s2_v_r      <= s1_v_r;
      if (rdy3) s3_v_r      <= s2_v_r;
      if (rdy4) s4_v_r      <= s3_v_r;
      if (rdy5) s5_v_r      <= s4_v_r;
      if (rdy6) out_valid_r <= s5_v_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: region test, source override and velocity magnitudes.
  // ---------------------------------------------------------------------------
  logic               src_w;
  logic               s1_src_r, s1_src_nxt;
  logic [30:0]        s1_rho_r, s1_rho_nxt;
  logic [47:0]        s1_e_r, s1_e_nxt;
  logic               s1_un_r, s1_un_nxt;
  logic               s1_vn_r, s1_vn_nxt;
  logic [31:0]        s1_au_r, s1_au_nxt;
  logic [31:0]        s1_av_r, s1_av_nxt;
  logic [16:0]        s1_fh_r, s1_fo_r, s1_fw_r;

  p2c_region u_region (
    .column (in_column),
    .row    (in_row),
    .cfg    (cfg_r),
    .src    (src_w)
  );

  always_comb begin
    s1_src_nxt = src_w;
    s1_rho_nxt = src_w ? cfg_r.density : in_density;
    s1_e_nxt   = src_w ? cfg_r.energy : in_internal_energy;
    s1_un_nxt  = in_velocity_x[31];
    s1_vn_nxt  = in_velocity_y[31];
    s1_au_nxt  = in_velocity_x[31] ? (32'h0 - in_velocity_x) : in_velocity_x;
    s1_av_nxt  = in_velocity_y[31] ? (32'h0 - in_velocity_y) : in_velocity_y;
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_src_r <= s1_src_nxt;
      s1_rho_r <= s1_rho_nxt;
      s1_e_r   <= s1_e_nxt;
      s1_un_r  <= s1_un_nxt;
      s1_vn_r  <= s1_vn_nxt;
      s1_au_r  <= s1_au_nxt;
      s1_av_r  <= s1_av_nxt;
      s1_fh_r  <= in_frac_hydrogen;
      s1_fo_r  <= in_frac_oxygen;
      s1_fw_r  <= in_frac_water;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: squares of the velocities and the density products.
  // ---------------------------------------------------------------------------
  logic [63:0] s2_usq_r, s2_usq_nxt;
  logic [63:0] s2_vsq_r, s2_vsq_nxt;
  logic [62:0] s2_mu_r, s2_mu_nxt;
  logic [62:0] s2_mv_r, s2_mv_nxt;
  logic [47:0] s2_ph_r, s2_ph_nxt;
  logic [47:0] s2_po_r, s2_po_nxt;
  logic [47:0] s2_pw_r, s2_pw_nxt;
  logic [30:0] s2_rho_r;
  logic [47:0] s2_e_r;
  logic        s2_un_r, s2_vn_r, s2_src_r;

  always_comb begin
    s2_usq_nxt = s1_au_r * s1_au_r;
    s2_vsq_nxt = s1_av_r * s1_av_r;
    s2_mu_nxt  = s1_rho_r * s1_au_r;
    s2_mv_nxt  = s1_rho_r * s1_av_r;
    s2_ph_nxt  = s1_rho_r * s1_fh_r;
    s2_po_nxt  = s1_rho_r * s1_fo_r;
    s2_pw_nxt  = s1_rho_r * s1_fw_r;
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_usq_r <= s2_usq_nxt;
      s2_vsq_r <= s2_vsq_nxt;
      s2_mu_r  <= s2_mu_nxt;
      s2_mv_r  <= s2_mv_nxt;
      s2_ph_r  <= s2_ph_nxt;
      s2_po_r  <= s2_po_nxt;
      s2_pw_r  <= s2_pw_nxt;
      s2_rho_r <= s1_rho_r;
      s2_e_r   <= s1_e_r;
      s2_un_r  <= s1_un_r;
      s2_vn_r  <= s1_vn_r;
      s2_src_r <= s1_src_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: kinetic term, rounding and saturation of momenta and species.
  // ---------------------------------------------------------------------------
  logic [63:0] ksum_w;
  logic [46:0] s3_ke_r, s3_ke_nxt;
  logic [31:0] s3_mx_r, s3_mx_nxt;
  logic [31:0] s3_my_r, s3_my_nxt;
  logic [30:0] s3_dh_r, s3_dh_nxt;
  logic [30:0] s3_dox_r, s3_dox_nxt;
  logic [30:0] s3_dw_r, s3_dw_nxt;
  logic [31:0] dh_full, dox_full, dw_full;
  logic [30:0] s3_rho_r;
  logic [47:0] s3_e_r;
  logic        s3_src_r;

  always_comb begin
    // Half the squared speed in Q.16, rounded half up.
    ksum_w     = s2_usq_r + s2_vsq_r + 64'h1_0000;
    s3_ke_nxt  = ksum_w[63:17];
    s3_mx_nxt  = rnd_sat_s32(s2_mu_r, s2_un_r);
    s3_my_nxt  = rnd_sat_s32(s2_mv_r, s2_vn_r);
    dh_full    = rnd_sat_s32({15'b0, s2_ph_r}, 1'b0);
    dox_full   = rnd_sat_s32({15'b0, s2_po_r}, 1'b0);
    dw_full    = rnd_sat_s32({15'b0, s2_pw_r}, 1'b0);
    s3_dh_nxt  = dh_full[30:0];
    s3_dox_nxt = dox_full[30:0];
    s3_dw_nxt  = dw_full[30:0];
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_ke_r  <= s3_ke_nxt;
      s3_mx_r  <= s3_mx_nxt;
      s3_my_r  <= s3_my_nxt;
      s3_dh_r  <= s3_dh_nxt;
      s3_dox_r <= s3_dox_nxt;
      s3_dw_r  <= s3_dw_nxt;
      s3_rho_r <= s2_rho_r;
      s3_e_r   <= s2_e_r;
      s3_src_r <= s2_src_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: specific total energy, split into sign and magnitude.
  // ---------------------------------------------------------------------------
  logic [48:0] etot_w;
  logic        s4_en_r, s4_en_nxt;
  logic [48:0] s4_emag_r, s4_emag_nxt;
  logic [31:0] s4_mx_r, s4_my_r;
  logic [30:0] s4_dh_r, s4_dox_r, s4_dw_r, s4_rho_r;
  logic        s4_src_r;

  always_comb begin
    etot_w      = {s3_e_r[47], s3_e_r} + {2'b00, s3_ke_r};
    s4_en_nxt   = etot_w[48];
    s4_emag_nxt = etot_w[48] ? (49'h0 - etot_w) : etot_w;
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      s4_en_r   <= s4_en_nxt;
      s4_emag_r <= s4_emag_nxt;
      s4_mx_r   <= s3_mx_r;
      s4_my_r   <= s3_my_r;
      s4_dh_r   <= s3_dh_r;
      s4_dox_r  <= s3_dox_r;
      s4_dw_r   <= s3_dw_r;
      s4_rho_r  <= s3_rho_r;
      s4_src_r  <= s3_src_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: density times energy magnitude as two partial products.
  // ---------------------------------------------------------------------------
  logic [62:0] s5_plo_r, s5_plo_nxt;
  logic [47:0] s5_phi_r, s5_phi_nxt;
  logic        s5_en_r;
  logic [31:0] s5_mx_r, s5_my_r;
  logic [30:0] s5_dh_r, s5_dox_r, s5_dw_r, s5_rho_r;
  logic        s5_src_r;

  always_comb begin
    s5_plo_nxt = s4_rho_r * s4_emag_r[31:0];
    s5_phi_nxt = s4_rho_r * s4_emag_r[48:32];
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      s5_plo_r <= s5_plo_nxt;
      s5_phi_r <= s5_phi_nxt;
      s5_en_r  <= s4_en_r;
      s5_mx_r  <= s4_mx_r;
      s5_my_r  <= s4_my_r;
      s5_dh_r  <= s4_dh_r;
      s5_dox_r <= s4_dox_r;
      s5_dw_r  <= s4_dw_r;
      s5_rho_r <= s4_rho_r;
      s5_src_r <= s4_src_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: combine the energy product, round, saturate; output register.
  // ---------------------------------------------------------------------------
  logic [79:0] eprod_w;
  logic [47:0] out_te_r, out_te_nxt;
  logic [30:0] out_rho_r, out_dh_r, out_dox_r, out_dw_r;
  logic [31:0] out_mx_r, out_my_r;
  logic        out_src_r;

  always_comb begin
    eprod_w    = {s5_phi_r, 32'b0} + {17'b0, s5_plo_r};
    out_te_nxt = rnd_sat_s48(eprod_w, s5_en_r);
  end

  always_ff @(posedge clk) begin
    if (rdy6) begin
      out_te_r  <= out_te_nxt;
      out_rho_r <= s5_rho_r;
      out_mx_r  <= s5_mx_r;
      out_my_r  <= s5_my_r;
      out_dh_r  <= s5_dh_r;
      out_dox_r <= s5_dox_r;
      out_dw_r  <= s5_dw_r;
      out_src_r <= s5_src_r;
    end
  end

  assign out_cons_density  = out_rho_r;
  assign out_momentum_x    = out_mx_r;
  assign out_momentum_y    = out_my_r;
  assign out_total_energy  = out_te_r;
  assign out_dens_hydrogen = out_dh_r;
  assign out_dens_oxygen   = out_dox_r;
  assign out_dens_water    = out_dw_r;
  assign out_in_source     = out_src_r;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  `P2C_ASSERT_NOW(a_stall_only_when_full, in_stall, s1_v_r && s2_v_r && s3_v_r && s4_v_r && s5_v_r && out_valid_r, "input stalled with a bubble in the pipeline")
  `P2C_ASSERT_NEXT(a_no_source_when_off, in_valid && !in_stall && !cfg_r.enable, s1_v_r && !s1_src_r, "source flag set with source mode off")
  `P2C_ASSERT_NEXT(a_stage3_holds, s3_v_r && !rdy4, s3_v_r && $stable(s3_ke_r) && $stable(s3_mx_r), "stalled stage lost or changed its word")

endmodule

>>> design/p2c_region.sv
// Source test: if enabled, on or left of source column or inside either circle.
module p2c_region (
  input  logic [p2c_pkg::COL_W-1:0] column,
  input  logic [p2c_pkg::ROW_W-1:0] row,
  input  p2c_pkg::p2c_cfg_t         cfg,
  output logic                      src
);

  localparam int CW   = $clog2(p2c_pkg::ROW_C2 + 1);
  localparam int DY_W = (CW > p2c_pkg::ROW_W) ? CW : p2c_pkg::ROW_W;
  localparam int DX_W = p2c_pkg::COL_W;
  localparam int SQ_W = ((2 * DX_W > 2 * DY_W) ? 2 * DX_W : 2 * DY_W) + 1;

  localparam logic [DY_W-1:0] C1 = DY_W'(p2c_pkg::ROW_C1);
  localparam logic [DY_W-1:0] C2 = DY_W'(p2c_pkg::ROW_C2);

  logic              left;
  logic [DX_W-1:0]   dx;
  logic [DY_W-1:0]   row_e;
  logic [DY_W-1:0]   dy1;
  logic [DY_W-1:0]   dy2;
  logic [SQ_W-1:0]   dxsq;
  logic [SQ_W-1:0]   d1;
  logic [SQ_W-1:0]   d2;
  logic [SQ_W-1:0]   rsq;

  always_comb begin
    left  = (column <= cfg.column);
    dx    = left ? (cfg.column - column) : (column - cfg.column);
    row_e = DY_W'(row);
    dy1   = (row_e >= C1) ? (row_e - C1) : (C1 - row_e);
    dy2   = (row_e >= C2) ? (row_e - C2) : (C2 - row_e);
    dxsq  = SQ_W'(dx) * SQ_W'(dx);
    d1    = dxsq + SQ_W'(dy1) * SQ_W'(dy1);
    d2    = dxsq + SQ_W'(dy2) * SQ_W'(dy2);
    rsq   = SQ_W'(cfg.radius_sq);
    src   = cfg.enable & (left | (d1 <= rsq) | (d2 <= rsq));
  end

endmodule

>>> test/tb_top.sv
// Self-checking testbench for the primitive to conservative cell converter.
`timescale 1ns / 1ps

module tb_top;
  import p2c_pkg::*;

  // Run limits and stretch lengths in clock cycles, and a cap on reported mismatches.
  localparam int LIMIT_CYCLES    = 200000;
  localparam int HOLD_OFF_CYCLES = 60;
  localparam int SETTLE_CYCLES   = 30;
  localparam int MAX_REPORTS     = 10;

  // Register indexes that the block does not decode; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] SPARE_IDX_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] SPARE_IDX_LAST  = 3'd7;

  // One grid cell in primitive form, as it travels on the input channel.
  typedef struct {
    logic [COL_W-1:0]   column;
    logic [ROW_W-1:0]   row;
    logic [30:0]        density;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [47:0] energy;
    logic [16:0]        frac_h;
    logic [16:0]        frac_o;
    logic [16:0]        frac_w;
  } cell_word_t;

  // One cell in conservative form, as it leaves on the result channel.
  typedef struct {
    logic [30:0]        cons_density;
    logic signed [31:0] momentum_x;
    logic signed [31:0] momentum_y;
    logic signed [47:0] total_energy;
    logic [30:0]        dens_h;
    logic [30:0]        dens_o;
    logic [30:0]        dens_w;
    logic               in_source;
  } conserved_t;

  logic clk;
  logic rst_n;

  logic               in_valid;
  logic               in_stall;
  logic [COL_W-1:0]   in_column;
  logic [ROW_W-1:0]   in_row;
  logic [30:0]        in_density;
  logic signed [31:0] in_velocity_x;
  logic signed [31:0] in_velocity_y;
  logic signed [47:0] in_internal_energy;
  logic [16:0]        in_frac_hydrogen;
  logic [16:0]        in_frac_oxygen;
  logic [16:0]        in_frac_water;

  logic               out_valid;
  logic               out_stall;
  logic [30:0]        out_cons_density;
  logic signed [31:0] out_momentum_x;
  logic signed [31:0] out_momentum_y;
  logic signed [47:0] out_total_energy;
  logic [30:0]        out_dens_hydrogen;
  logic [30:0]        out_dens_oxygen;
  logic [30:0]        out_dens_water;
  logic               out_in_source;

  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Our own copy of the source registers, updated on every accepted register write.
  p2c_cfg_t src_cfg;

  // Conservative cells still owed by the block, oldest first.
  conserved_t owed_cells[$];

  int mismatches;
  int results_seen;
  int cycle_count;

  // Idle switches for the two sides, and the handshake with the long hold-off process.
  logic in_idle_en;
  logic out_idle_en;
  logic hold_off_req;
  logic hold_active;

  primitive_to_conservative dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_column          (in_column),
    .in_row             (in_row),
    .in_density         (in_density),
    .in_velocity_x      (in_velocity_x),
    .in_velocity_y      (in_velocity_y),
    .in_internal_energy (in_internal_energy),
    .in_frac_hydrogen   (in_frac_hydrogen),
    .in_frac_oxygen     (in_frac_oxygen),
    .in_frac_water      (in_frac_water),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_cons_density   (out_cons_density),
    .out_momentum_x     (out_momentum_x),
    .out_momentum_y     (out_momentum_y),
    .out_total_energy   (out_total_energy),
    .out_dens_hydrogen  (out_dens_hydrogen),
    .out_dens_oxygen    (out_dens_oxygen),
    .out_dens_water     (out_dens_water),
    .out_in_source      (out_in_source),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Multiplies a Q15.16 density by a Q.16 value, drops 16 fraction bits with
  // rounding to nearest on the magnitude (ties away from zero), and saturates
  // to a signed field of the given width. The product is formed at full width,
  // so no intermediate can wrap.
  function automatic logic signed [63:0] scaled_product(input logic [30:0] rho,
                                                        input logic signed [63:0] x,
                                                        input int bits);
    logic [63:0]  mag;
    logic [127:0] q;
    logic [127:0] lim;
    mag = (x < 0) ? -x : x;
    q = ({97'd0, rho} * {64'd0, mag} + 128'h8000) >> 16;
    if (x < 0) begin
      lim = 128'd1 << (bits - 1);
      if (q > lim) q = lim;
      return -$signed(q[63:0]);
    end
    lim = (128'd1 << (bits - 1)) - 128'd1;
    if (q > lim) q = lim;
    return $signed(q[63:0]);
  endfunction

  // Works out the conservative cell for one primitive cell under the current
  // register settings.
  function automatic conserved_t convert_cell(input cell_word_t c);
    conserved_t         r;
    logic [30:0]        rho;
    logic signed [63:0] e64;
    logic signed [63:0] u64;
    logic signed [63:0] v64;
    logic signed [63:0] ke;
    logic signed [63:0] etot;
    logic [63:0]        au;
    logic [63:0]        av;
    logic [127:0]       ksum;
    int                 dx;
    int                 dy_lo;
    int                 dy_hi;
    logic               hit;
    rho = c.density;
    e64 = c.energy;
    u64 = c.vel_x;
    v64 = c.vel_y;
    hit = 1'b0;
    // Source region: on or left of the source column, or inside either circle.
    // The circle test is on exact squared distances, boundary included.
    if (src_cfg.enable) begin
      dx    = int'(c.column) - int'(src_cfg.column);
      dy_lo = int'(c.row) - ROW_C1;
      dy_hi = int'(c.row) - ROW_C2;
      hit = (dx <= 0) ||
            (dx * dx + dy_lo * dy_lo <= int'(src_cfg.radius_sq)) ||
            (dx * dx + dy_hi * dy_hi <= int'(src_cfg.radius_sq));
      if (hit) begin
        rho = src_cfg.density;
        e64 = src_cfg.energy;
      end
    end
    // Half the squared speed, exact in Q.32, then rounded half up to Q.16.
    au   = (u64 < 0) ? -u64 : u64;
    av   = (v64 < 0) ? -v64 : v64;
    ksum = au * au + av * av;
    ke   = 64'((ksum + 128'd65536) >> 17);
    etot = e64 + ke;
    r.cons_density = rho;
    r.momentum_x   = 32'(scaled_product(rho, u64, 32));
    r.momentum_y   = 32'(scaled_product(rho, v64, 32));
    r.total_energy = 48'(scaled_product(rho, etot, 48));
    r.dens_h       = 31'(scaled_product(rho, 64'(c.frac_h), 32));
    r.dens_o       = 31'(scaled_product(rho, 64'(c.frac_o), 32));
    r.dens_w       = 31'(scaled_product(rho, 64'(c.frac_w), 32));
    r.in_source    = hit;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Idle run length: mostly none, often a few cycles, now and then a long one.
  function automatic int idle_run(input logic enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  function automatic cell_word_t make_cell(input logic [COL_W-1:0] col,
                                           input logic [ROW_W-1:0] row,
                                           input logic [30:0] rho,
                                           input logic [31:0] u,
                                           input logic [31:0] v,
                                           input logic [47:0] e,
                                           input logic [16:0] fh,
                                           input logic [16:0] fo,
                                           input logic [16:0] fw);
    cell_word_t c;
    c.column  = col;
    c.row     = row;
    c.density = rho;
    c.vel_x   = u;
    c.vel_y   = v;
    c.energy  = e;
    c.frac_h  = fh;
    c.frac_o  = fo;
    c.frac_w  = fw;
    return c;
  endfunction

  // Random cell. Half the cells land near the source column and one of the
  // circle centres, so the region edges are crossed often. Magnitudes mix full
  // range (saturation) with small values (the exact arithmetic path).
  function automatic cell_word_t rand_cell();
    cell_word_t c;
    int         pick;
    pick = $urandom_range(0, 3);
    if (pick < 2) begin
      c.column = COL_W'(int'(src_cfg.column) + int'($urandom_range(0, 16)) - 8);
      c.row    = ROW_W'(((pick == 0) ? ROW_C1 : ROW_C2) + int'($urandom_range(0, 16)) - 8);
    end else begin
      c.column = COL_W'($urandom);
      c.row    = ROW_W'($urandom);
    end
    case ($urandom_range(0, 2))
      0:       c.density = 31'($urandom);
      1:       c.density = 31'($urandom_range(0, 32'h0004_0000));
      default: c.density = 31'($urandom_range(0, 32'h0000_0100) << $urandom_range(0, 22));
    endcase
    if ($urandom_range(0, 1) == 0) begin
      c.vel_x = $urandom;
      c.vel_y = $urandom;
    end else begin
      c.vel_x = 32'(int'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000);
      c.vel_y = 32'(int'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000);
    end
    if ($urandom_range(0, 1) == 0) begin
      c.energy = 48'({$urandom, $urandom});
    end else begin
      c.energy = 48'(longint'($urandom_range(0, 32'h0100_0000)) - 64'h0080_0000);
    end
    if ($urandom_range(0, 7) == 0) begin
      c.frac_h = 17'($urandom);
      c.frac_o = 17'($urandom);
      c.frac_w = 17'($urandom);
    end else begin
      c.frac_h = 17'($urandom_range(0, 65536));
      c.frac_o = 17'($urandom_range(0, 65536));
      c.frac_w = 17'($urandom_range(0, 65536));
    end
    return c;
  endfunction

  function automatic cell_word_t place_cell(input logic [COL_W-1:0] col,
                                            input logic [ROW_W-1:0] row);
    cell_word_t c;
    c = rand_cell();
    c.column = col;
    c.row    = row;
    return c;
  endfunction

  function automatic p2c_cfg_t rand_settings();
    p2c_cfg_t s;
    s.enable    = ($urandom_range(0, 3) != 0);
    s.column    = COL_W'($urandom);
    s.radius_sq = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 400));
    s.density   = ($urandom_range(0, 1) == 0) ? 31'($urandom)
                                              : 31'($urandom_range(0, 32'h0008_0000));
    s.energy    = ($urandom_range(0, 1) == 0)
                  ? 48'({$urandom, $urandom})
                  : 48'(longint'($urandom_range(0, 32'h0100_0000)) - 64'h0080_0000);
    return s;
  endfunction

  // Fills the unused high bits of a register write with noise; the block must
  // keep only the register's own width.
  function automatic logic [CFG_DATA_W-1:0] with_noise(input logic [CFG_DATA_W-1:0] v,
                                                       input int w);
    logic [CFG_DATA_W-1:0] r;
    r = CFG_DATA_W'({$urandom, $urandom});
    if (w >= CFG_DATA_W) return v;
    return (r << w) | v;
  endfunction

  // ---------------------------------------------------------------------------
  // Channel tasks
  // ---------------------------------------------------------------------------

  // Offers one cell after a random idle gap and holds it until the block takes
  // it. Valid stays high after acceptance so that back-to-back words need no
  // extra edge on valid; drain() lowers it when a burst ends.
  task automatic send_cell(input cell_word_t c);
    int gap;
    gap = idle_run(in_idle_en);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid           <= 1'b1;
    in_column          <= c.column;
    in_row             <= c.row;
    in_density         <= c.density;
    in_velocity_x      <= c.vel_x;
    in_velocity_y      <= c.vel_y;
    in_internal_energy <= c.energy;
    in_frac_hydrogen   <= c.frac_h;
    in_frac_oxygen     <= c.frac_o;
    in_frac_water      <= c.frac_w;
    do @(posedge clk); while (in_stall);
    owed_cells.push_back(convert_cell(c));
  endtask

  // Ends a burst and waits until every owed cell has come back. The block
  // produces exactly one result per word, so an empty queue means it is idle.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (owed_cells.size() != 0) @(posedge clk);
  endtask

  // One register write. Valid is left high; the caller lowers it after the
  // last write of a batch.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ENABLE:    src_cfg.enable    = data[0];
      CFG_COLUMN:    src_cfg.column    = data[COL_W-1:0];
      CFG_RADIUS_SQ: src_cfg.radius_sq = data[15:0];
      CFG_DENSITY:   src_cfg.density   = data[30:0];
      CFG_ENERGY:    src_cfg.energy    = data[47:0];
      default:       ;
    endcase
  endtask

  // Writes all five source registers. Only called while the block is idle.
  task automatic apply_settings(input p2c_cfg_t s);
    write_reg(CFG_ENABLE,    with_noise(CFG_DATA_W'(s.enable), 1));
    write_reg(CFG_COLUMN,    with_noise(CFG_DATA_W'(s.column), COL_W));
    write_reg(CFG_RADIUS_SQ, with_noise(CFG_DATA_W'(s.radius_sq), 16));
    write_reg(CFG_DENSITY,   with_noise(CFG_DATA_W'(s.density), 31));
    write_reg(CFG_ENERGY,    CFG_DATA_W'(s.energy));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: stall generation and checking
  // ---------------------------------------------------------------------------

  // Drives out_stall. Normally it stalls in random runs; on request it holds
  // off for one long stretch, counted here, so the pipeline fills and the
  // block has to stall its input.
  initial begin : result_stall
    int run;
    out_stall   = 1'b0;
    hold_active = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_active  = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
        hold_active = 1'b0;
      end else begin
        run = idle_run(out_idle_en);
        if (run > 0) begin
          out_stall <= 1'b1;
          repeat (run) @(negedge clk);
        end
        out_stall <= 1'b0;
      end
    end
  end

  function automatic void check_field(input string name,
                                      input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("%s mismatch on result word %0d: expected %h, got %h",
                 name, results_seen, want, got);
      end
    end
  endfunction

  // Every word taken from the result channel is compared with the oldest
  // owed cell, one field at a time.
  always @(posedge clk) begin : result_check
    conserved_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (owed_cells.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("result word %0d arrived with nothing owed", results_seen);
        end
      end else begin
        want = owed_cells.pop_front();
        check_field("cons_density",  want.cons_density, out_cons_density);
        check_field("momentum_x",    want.momentum_x,   out_momentum_x);
        check_field("momentum_y",    want.momentum_y,   out_momentum_y);
        check_field("total_energy",  want.total_energy, out_total_energy);
        check_field("dens_hydrogen", want.dens_h,       out_dens_hydrogen);
        check_field("dens_oxygen",   want.dens_o,       out_dens_oxygen);
        check_field("dens_water",    want.dens_w,       out_dens_water);
        check_field("in_source",     want.in_source,    out_in_source);
      end
      results_seen++;
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles with %0d words owed", cycle_count, owed_cells.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values of the registers: source on, column 20, squared radius 25.
  // Cells sit on the left edge, on the source column, exactly on both circle
  // boundaries, one step outside them, and at the far corner of the grid.
  task automatic test_reset_defaults();
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
    send_cell(place_cell(9'd0, 8'd0));
    send_cell(place_cell(9'd20, 8'd255));
    send_cell(place_cell(9'd21, 8'd128));
    send_cell(place_cell(9'd25, 8'd64));
    send_cell(place_cell(9'd26, 8'd64));
    send_cell(place_cell(9'd23, 8'd196));
    send_cell(place_cell(9'd24, 8'd196));
    send_cell(place_cell(9'd511, 8'd255));
    drain();
  endtask

  // With the source off, inputs pass unchanged into the arithmetic: field extremes,
  // saturation of the momenta, energy and species densities, fractions above one,
  // rounding ties in both the kinetic term and the density products.
  task automatic test_field_extremes();
    p2c_cfg_t s;
    s = rand_settings();
    s.enable = 1'b0;
    apply_settings(s);
    send_cell(make_cell(9'd0, 8'd0, 31'h0, 32'h7FFF_FFFF, 32'h8000_0000,
                        48'h7FFF_FFFF_FFFF, 17'h0, 17'h0, 17'h0));
    send_cell(make_cell(9'd511, 8'd255, 31'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                        48'h8000_0000_0000, 17'h1_0000, 17'h1_0000, 17'h1_0000));
    send_cell(make_cell(9'd0, 8'd64, 31'h7FFF_FFFF, 32'h0, 32'h0,
                        48'h7FFF_FFFF_FFFF, 17'h1_FFFF, 17'h1_FFFF, 17'h1_FFFF));
    send_cell(make_cell(9'd1, 8'd192, 31'h1, 32'h0000_8000, 32'hFFFF_8000,
                        48'h0000_0000_8000, 17'h0_8000, 17'h0_8000, 17'h0_8000));
    send_cell(make_cell(9'd2, 8'd3, 31'h3, 32'h0000_0001, 32'hFFFF_FFFF,
                        48'hFFFF_FFFF_FFFF, 17'h1, 17'h0_FFFF, 17'h1_0000));
    send_cell(make_cell(9'd100, 8'd100, 31'h0001_0000, 32'h0000_0100, 32'h0,
                        48'h0, 17'h0, 17'h0, 17'h0));
    send_cell(make_cell(9'd300, 8'd7, 31'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                        48'h8000_0000_0000, 17'h0, 17'h0, 17'h0));
    send_cell(make_cell(9'd5, 8'd5, 31'h0001_0000, 32'h0001_8000, 32'hFFFE_8000,
                        48'h0000_0001_0000, 17'h0_AAAA, 17'h1_5555, 17'h1_0000));
    send_cell(make_cell(9'd400, 8'd200, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        48'h7FFF_FFFF_FFFF, 17'h0, 17'h0, 17'h0));
    drain();
  endtask

  // Writes to the undecoded indexes carry all ones; none of them may disturb
  // the source registers written just before.
  task automatic test_spare_indexes();
    p2c_cfg_t s;
    s.enable    = 1'b1;
    s.column    = 9'd100;
    s.radius_sq = 16'd100;
    s.density   = 31'h0002_0000;
    s.energy    = 48'h0000_0003_0000;
    apply_settings(s);
    for (int i = SPARE_IDX_FIRST; i <= SPARE_IDX_LAST; i++) begin
      write_reg(CFG_IDX_W'(i), '1);
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
    send_cell(place_cell(9'd50, 8'd10));
    send_cell(place_cell(9'd200, 8'd10));
    send_cell(place_cell(9'd108, 8'd58));
    drain();
  endtask

  // Register extremes: region reduced to column zero with a zero radius, and
  // the widest region with the largest radius; source density and energy at
  // their limits. A last batch runs under random settings with the source on.
  task automatic test_config_extremes();
    p2c_cfg_t s;
    s.enable    = 1'b1;
    s.column    = '0;
    s.radius_sq = '0;
    s.density   = 31'h7FFF_FFFF;
    s.energy    = 48'h7FFF_FFFF_FFFF;
    apply_settings(s);
    repeat (25) send_cell(rand_cell());
    drain();
    s.column    = '1;
    s.radius_sq = '1;
    s.density   = '0;
    s.energy    = 48'h8000_0000_0000;
    apply_settings(s);
    repeat (25) send_cell(rand_cell());
    drain();
    s = rand_settings();
    s.enable = 1'b1;
    apply_settings(s);
    repeat (25) send_cell(rand_cell());
    drain();
  endtask

  // Random phases, each under fresh settings. Every phase ends with the sender
  // paused until all owed cells are back. One phase runs with no idling at all.
  task automatic test_random_stream();
    for (int p = 0; p < 8; p++) begin
      in_idle_en  = (p != 3);
      out_idle_en = (p != 3);
      apply_settings(rand_settings());
      repeat (40) send_cell(rand_cell());
      drain();
    end
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
  endtask

  // Long hold-off on the result side while the sender keeps offering words
  // back to back: the pipeline fills and in_stall must hold the sender.
  task automatic test_backpressure();
    in_idle_en   = 1'b0;
    hold_off_req = 1'b1;
    wait (hold_active);
    repeat (30) send_cell(rand_cell());
    in_idle_en = 1'b1;
    drain();
  endtask

  task automatic finish_run();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && owed_cells.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  endtask

  // Reset is held with every input at a known value, and the local register
  // copy starts from the reset values.
  initial begin
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_column          = '0;
    in_row             = '0;
    in_density         = '0;
    in_velocity_x      = '0;
    in_velocity_y      = '0;
    in_internal_energy = '0;
    in_frac_hydrogen   = '0;
    in_frac_oxygen     = '0;
    in_frac_water      = '0;
    cfg_valid          = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    in_idle_en         = 1'b0;
    out_idle_en        = 1'b0;
    hold_off_req       = 1'b0;
    mismatches         = 0;
    results_seen       = 0;
    cycle_count        = 0;
    src_cfg.enable     = 1'b1;
    src_cfg.column     = 9'd20;
    src_cfg.radius_sq  = 16'd25;
    src_cfg.density    = 31'd65536;
    src_cfg.energy     = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_field_extremes();
    test_spare_indexes();
    test_config_extremes();
    test_random_stream();
    test_backpressure();
    finish_run();
  end

endmodule

>>> sim.f
+incdir+design
design/p2c_pkg.sv
design/p2c_region.sv
design/primitive_to_conservative.sv
test/tb_top.sv
